FILE: rtl/isc_pkg.sv
// ----------------------------------------------------------------------------
// isc_pkg
// Shared types and constants for the idle standby controller: command codes,
// register indexes, the delay table and the result record.
// ----------------------------------------------------------------------------
package isc_pkg;

	// Command codes carried by an input beat.
	typedef enum logic [2:0] {
		CMD_TICK   = 3'd0,
		CMD_FORCE  = 3'd1,
		CMD_CANCEL = 3'd2,
		CMD_WAKE   = 3'd3,
		CMD_REBASE = 3'd4,
		CMD_CLEAR  = 3'd5
	} isc_cmd_t;

	// Configuration register indexes.
	typedef enum logic {
		REG_ARMED      = 1'b0,
		REG_DELAY_STEP = 1'b1
	} isc_reg_t;

	localparam int unsigned MARGIN_SECONDS = 60;
	localparam logic [31:0] MS_PER_SECOND  = 32'd1000;
	localparam logic [31:0] MARGIN_MS      = 32'(MARGIN_SECONDS * 1000);

	// Standby delay in ms for each delay step (1, 3, 5, 10 minutes).
	function automatic logic [31:0] delay_ms(input logic [1:0] step);
		logic [31:0] d;
		case (step)
			2'd0:    d = 32'd60000;
			2'd1:    d = 32'd180000;
			2'd2:    d = 32'd300000;
			default: d = 32'd600000;
		endcase
		return d;
	endfunction

	// One result beat.
	typedef struct packed {
		logic        action_taken;
		logic        ambient_mode;
		logic [31:0] sleep_count;
		logic [31:0] wake_count;
		logic [31:0] rebase_count;
		logic [31:0] cancel_count;
		logic [31:0] ticks_seen;
		logic [31:0] idle_max_ms;
		logic [31:0] last_idle_ms;
		logic [1:0]  last_origin;
		logic        phantom_suspect;
	} isc_result_t;

endpackage

FILE: rtl/isc_engine.sv
// ----------------------------------------------------------------------------
// isc_engine
// Holds the controller state and applies one command per cycle when fired,
// producing the result record that reflects the state after the command.
// ----------------------------------------------------------------------------
module isc_engine (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                fire,
	input  logic [2:0]          command,
	input  logic [31:0]         idle_ms,
	input  logic [1:0]          wake_origin,
	input  logic                armed,
	input  logic [1:0]          delay_step,
	output isc_pkg::isc_result_t result
);

	logic        mode_q;
	logic [31:0] sleeps_q;
	logic [31:0] wakes_q;
	logic [31:0] rebases_q;
	logic [31:0] cancels_q;
	logic [31:0] ticks_q;
	logic [31:0] observed_q;
	logic [31:0] peak_q;
	logic [31:0] recent_q;
	logic [1:0]  source_q;

	logic        mode_n;
	logic [31:0] sleeps_n;
	logic [31:0] wakes_n;
	logic [31:0] rebases_n;
	logic [31:0] cancels_n;
	logic [31:0] ticks_n;
	logic [31:0] observed_n;
	logic [31:0] peak_n;
	logic [31:0] recent_n;
	logic [1:0]  source_n;
	logic        action;
	logic        allow;
	logic [31:0] delay;
	logic [31:0] limit;

	assign delay = isc_pkg::delay_ms(delay_step);
	assign limit = delay + isc_pkg::MARGIN_MS;
	assign allow = armed && !mode_q;

	// Next-state logic for the command in hand.
	always_comb begin
		mode_n     = mode_q;
		sleeps_n   = sleeps_q;
		wakes_n    = wakes_q;
		rebases_n  = rebases_q;
		cancels_n  = cancels_q;
		ticks_n    = ticks_q;
		observed_n = observed_q;
		peak_n     = peak_q;
		recent_n   = recent_q;
		source_n   = source_q;
		action     = 1'b0;
		case (command)
			isc_pkg::CMD_TICK: begin
				ticks_n    = ticks_q + 32'd1;
				observed_n = observed_q + isc_pkg::MS_PER_SECOND;
				recent_n   = idle_ms;
				if (idle_ms > peak_q) begin
					peak_n = idle_ms;
				end
				if (allow && idle_ms >= delay) begin
					mode_n   = 1'b1;
					sleeps_n = sleeps_q + 32'd1;
					action   = 1'b1;
				end
			end
			isc_pkg::CMD_FORCE: begin
				if (allow) begin
					mode_n   = 1'b1;
					sleeps_n = sleeps_q + 32'd1;
					action   = 1'b1;
				end
			end
			isc_pkg::CMD_CANCEL: begin
				if (mode_q) begin
					mode_n    = 1'b0;
					sleeps_n  = (sleeps_q != 32'd0) ? sleeps_q - 32'd1 : sleeps_q;
					cancels_n = cancels_q + 32'd1;
				end
			end
			isc_pkg::CMD_WAKE: begin
				if (mode_q) begin
					mode_n   = 1'b0;
					wakes_n  = wakes_q + 32'd1;
					source_n = wake_origin;
					action   = 1'b1;
				end
			end
			isc_pkg::CMD_REBASE: begin
				rebases_n = rebases_q + 32'd1;
			end
			isc_pkg::CMD_CLEAR: begin
				sleeps_n   = '0;
				wakes_n    = '0;
				rebases_n  = '0;
				cancels_n  = '0;
				ticks_n    = '0;
				observed_n = '0;
				peak_n     = '0;
				recent_n   = '0;
				source_n   = '0;
			end
			default: begin
			end
		endcase
	end

	// Result record built from the updated state.
	always_comb begin
		result.action_taken    = action;
		result.ambient_mode    = mode_n;
		result.sleep_count     = sleeps_n;
		result.wake_count      = wakes_n;
		result.rebase_count    = rebases_n;
		result.cancel_count    = cancels_n;
		result.ticks_seen      = ticks_n;
		result.idle_max_ms     = peak_n;
		result.last_idle_ms    = recent_n;
		result.last_origin     = source_n;
		result.phantom_suspect = armed && (sleeps_n == 32'd0) && (peak_n < delay) &&
			(observed_n > limit);
	end

	// State registers. The observed-ms total tracks ticks times 1000.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q     <= 1'b0;
			sleeps_q   <= '0;
			wakes_q    <= '0;
			rebases_q  <= '0;
			cancels_q  <= '0;
			ticks_q    <= '0;
			observed_q <= '0;
			peak_q     <= '0;
			recent_q   <= '0;
			source_q   <= '0;
		end else if (fire) begin
			mode_q     <= mode_n;
			sleeps_q   <= sleeps_n;
			wakes_q    <= wakes_n;
			rebases_q  <= rebases_n;
			cancels_q  <= cancels_n;
			ticks_q    <= ticks_n;
			observed_q <= observed_n;
			peak_q     <= peak_n;
			recent_q   <= recent_n;
			source_q   <= source_n;
		end
	end

	// A successful wake always leaves the block active.
	a_wake_active: assert property (@(posedge clk) disable iff (!arst_n)
		fire && action && command == isc_pkg::CMD_WAKE |=> !mode_q)
		else $error("wake left block in ambient");

	// Entering ambient by tick or force bumps the sleep counter by one.
	a_sleep_bump: assert property (@(posedge clk) disable iff (!arst_n)
		fire && action && (command == isc_pkg::CMD_TICK || command == isc_pkg::CMD_FORCE)
		|=> mode_q && sleeps_q == $past(sleeps_q) + 32'd1)
		else $error("sleep entry did not count");

	// The observed-ms total stays in step with the tick count.
	a_observed: assert property (@(posedge clk) disable iff (!arst_n)
		observed_q == 32'(ticks_q * isc_pkg::MS_PER_SECOND))
		else $error("observed time out of step with ticks");

	// State only moves when an item is fired.
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		!fire |=> $stable(sleeps_q) && $stable(mode_q) && $stable(ticks_q))
		else $error("state changed without an item");

endmodule

FILE: rtl/idle_standby_controller_core.sv
// ----------------------------------------------------------------------------
// idle_standby_controller_core
// Active/ambient standby controller with counters and phantom-touch flag.
// ----------------------------------------------------------------------------
// Usage:
//   Input beats (command, idle_ms, wake_origin) arrive on in_valid/in_ready
//   and each produces exactly one result beat on out_valid/out_ready.
//   A beat is registered in the input register on acceptance, processed by
//   the state engine once the output slot is free, and its result is
//   registered in the output register, where out_valid presents it.
//   Throughput is one beat per cycle while the receiver takes every result;
//   the state engine works out each result combinationally, so consecutive
//   beats do not wait on each other.
//   When the receiver stalls, the result stays in the output register and
//   one further beat is held in the input register; in_ready drops only
//   when both are full.
//   Configuration (armed, delay_step) is written through cfg_we, cfg_index
//   and cfg_data while no beat is in flight.
//   Reset (arst_n low) returns the block to active mode with all counters
//   and idle records at zero, armed set, and a three-minute delay.
// ----------------------------------------------------------------------------
module idle_standby_controller_core (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic        cfg_index,
	input  logic [1:0]  cfg_data,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [2:0]  command,
	input  logic [31:0] idle_ms,
	input  logic [1:0]  wake_origin,
	output logic        out_valid,
	input  logic        out_ready,
	output logic        action_taken,
	output logic        ambient_mode,
	output logic [31:0] sleep_count,
	output logic [31:0] wake_count,
	output logic [31:0] rebase_count,
	output logic [31:0] cancel_count,
	output logic [31:0] ticks_seen,
	output logic [31:0] idle_max_ms,
	output logic [31:0] last_idle_ms,
	output logic [1:0]  last_origin,
	output logic        phantom_suspect
);

	logic                armed_q;
	logic [1:0]          delay_step_q;
	logic                valid_s1;
	logic [2:0]          command_s1;
	logic [31:0]         idle_ms_s1;
	logic [1:0]          origin_s1;
	logic                valid_s2;
	isc_pkg::isc_result_t result;
	isc_pkg::isc_result_t result_s2;
	logic                advance;
	logic                accept;

	// Configuration registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			armed_q      <= 1'b1;
			delay_step_q <= 2'd1;
		end else if (cfg_we) begin
			case (cfg_index)
				isc_pkg::REG_ARMED:      armed_q      <= cfg_data[0];
				isc_pkg::REG_DELAY_STEP: delay_step_q <= cfg_data;
				default: begin
				end
			endcase
		end
	end

	// Handshake: the input stage moves on whenever the output slot is free.
	assign advance  = valid_s1 && (!valid_s2 || out_ready);
	assign in_ready = !valid_s1 || advance;
	assign accept   = in_valid && in_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			if (in_ready) begin
				valid_s1 <= in_valid;
			end
			if (advance) begin
				valid_s2 <= 1'b1;
			end else if (out_ready) begin
				valid_s2 <= 1'b0;
			end
		end
	end

	// Input register.
	always_ff @(posedge clk) begin
		if (accept) begin
			command_s1 <= command;
			idle_ms_s1 <= idle_ms;
			origin_s1  <= wake_origin;
		end
	end

	isc_engine u_engine (
		.clk         (clk),
		.arst_n      (arst_n),
		.fire        (advance),
		.command     (command_s1),
		.idle_ms     (idle_ms_s1),
		.wake_origin (origin_s1),
		.armed       (armed_q),
		.delay_step  (delay_step_q),
		.result      (result)
	);

	// Result register.
	always_ff @(posedge clk) begin
		if (advance) begin
			result_s2 <= result;
		end
	end

	assign out_valid       = valid_s2;
	assign action_taken    = result_s2.action_taken;
	assign ambient_mode    = result_s2.ambient_mode;
	assign sleep_count     = result_s2.sleep_count;
	assign wake_count      = result_s2.wake_count;
	assign rebase_count    = result_s2.rebase_count;
	assign cancel_count    = result_s2.cancel_count;
	assign ticks_seen      = result_s2.ticks_seen;
	assign idle_max_ms     = result_s2.idle_max_ms;
	assign last_idle_ms    = result_s2.last_idle_ms;
	assign last_origin     = result_s2.last_origin;
	assign phantom_suspect = result_s2.phantom_suspect;

	// Back-pressure only when both stages hold a beat and the receiver stalls.
	a_ready: assert property (@(posedge clk) disable iff (!arst_n)
		!in_ready |-> valid_s1 && valid_s2 && !out_ready)
		else $error("input stalled without cause");

	// Every beat leaving the input stage shows up as a result next cycle.
	a_advance: assert property (@(posedge clk) disable iff (!arst_n)
		advance |=> out_valid)
		else $error("result lost after advance");

	// A result not taken is never dropped.
	a_keep: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid)
		else $error("pending result dropped");

endmodule

FILE: tb/isc_result_checker.sv
// ----------------------------------------------------------------------------
// isc_result_checker
// Watches the configuration port and both beat channels of the idle standby
// controller. It keeps its own copy of the controller state, works out the
// result of every accepted input beat, and compares each accepted result beat
// field by field with the oldest expected one.
// ----------------------------------------------------------------------------
module isc_result_checker (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic        cfg_index,
	input  logic [1:0]  cfg_data,
	input  logic        in_valid,
	input  logic        in_ready,
	input  logic [2:0]  command,
	input  logic [31:0] idle_ms,
	input  logic [1:0]  wake_origin,
	input  logic        out_valid,
	input  logic        out_ready,
	input  logic        action_taken,
	input  logic        ambient_mode,
	input  logic [31:0] sleep_count,
	input  logic [31:0] wake_count,
	input  logic [31:0] rebase_count,
	input  logic [31:0] cancel_count,
	input  logic [31:0] ticks_seen,
	input  logic [31:0] idle_max_ms,
	input  logic [31:0] last_idle_ms,
	input  logic [1:0]  last_origin,
	input  logic        phantom_suspect,
	input  logic        end_of_test,
	output int          outstanding,
	output int          mismatches
);
	timeunit 1ns;
	timeprecision 1ps;

	// Predicted configuration.
	logic        p_armed;
	logic [1:0]  p_delay_step;

	// Predicted controller state.
	logic        p_ambient;
	logic [31:0] p_sleeps;
	logic [31:0] p_wakes;
	logic [31:0] p_rebases;
	logic [31:0] p_cancels;
	logic [31:0] p_ticks;
	logic [31:0] p_peak_idle;
	logic [31:0] p_recent_idle;
	logic [1:0]  p_wake_source;

	isc_pkg::isc_result_t expected_results[$];
	isc_pkg::isc_result_t predicted;
	isc_pkg::isc_result_t oldest;
	isc_pkg::isc_result_t observed;
	int          result_index;
	logic        leftover_reported;

	initial mismatches = 0;

	// Standby delay in ms for the current delay step.
	function automatic logic [31:0] standby_delay();
		logic [31:0] minutes;
		case (p_delay_step)
			2'd0:    minutes = 32'd1;
			2'd1:    minutes = 32'd3;
			2'd2:    minutes = 32'd5;
			default: minutes = 32'd10;
		endcase
		return minutes * 32'd60 * 32'd1000;
	endfunction

	function automatic logic may_enter_ambient();
		return p_armed && !p_ambient;
	endfunction

	// Phantom touch: armed, never slept, never idle long enough, yet enough
	// ticks went by to cover the delay plus the margin (32-bit wrap).
	function automatic logic phantom_flag();
		logic [31:0] d;
		logic [31:0] observed_ms;
		logic [31:0] limit_ms;
		d = standby_delay();
		observed_ms = p_ticks * 32'd1000;
		limit_ms = d + 32'(isc_pkg::MARGIN_SECONDS) * 32'd1000;
		if (!p_armed || p_sleeps != 32'd0 || p_peak_idle >= d)
			return 1'b0;
		return observed_ms > limit_ms;
	endfunction

	task automatic reset_controller();
		p_armed = 1'b1;
		p_delay_step = 2'd1;
		p_ambient = 1'b0;
		p_sleeps = '0;
		p_wakes = '0;
		p_rebases = '0;
		p_cancels = '0;
		p_ticks = '0;
		p_peak_idle = '0;
		p_recent_idle = '0;
		p_wake_source = '0;
	endtask

	// Advance the predicted state by one command and build its result.
	task automatic apply_command(input logic [2:0] cmd, input logic [31:0] idle,
		input logic [1:0] origin, output isc_pkg::isc_result_t r);
		logic took;
		took = 1'b0;
		case (cmd)
			isc_pkg::CMD_TICK: begin
				p_ticks++;
				p_recent_idle = idle;
				if (idle > p_peak_idle)
					p_peak_idle = idle;
				if (may_enter_ambient() && idle >= standby_delay()) begin
					p_ambient = 1'b1;
					p_sleeps++;
					took = 1'b1;
				end
			end
			isc_pkg::CMD_FORCE: begin
				if (may_enter_ambient()) begin
					p_ambient = 1'b1;
					p_sleeps++;
					took = 1'b1;
				end
			end
			isc_pkg::CMD_CANCEL: begin
				// Undo the transition; the sleep count never goes below zero.
				if (p_ambient) begin
					p_ambient = 1'b0;
					if (p_sleeps != 32'd0)
						p_sleeps--;
					p_cancels++;
				end
			end
			isc_pkg::CMD_WAKE: begin
				if (p_ambient) begin
					p_ambient = 1'b0;
					p_wakes++;
					p_wake_source = origin;
					took = 1'b1;
				end
			end
			isc_pkg::CMD_REBASE: begin
				p_rebases++;
			end
			isc_pkg::CMD_CLEAR: begin
				// Counters and records go to zero; mode and registers stay.
				p_sleeps = '0;
				p_wakes = '0;
				p_rebases = '0;
				p_cancels = '0;
				p_ticks = '0;
				p_peak_idle = '0;
				p_recent_idle = '0;
				p_wake_source = '0;
			end
			default: begin
			end
		endcase
		r.action_taken = took;
		r.ambient_mode = p_ambient;
		r.sleep_count = p_sleeps;
		r.wake_count = p_wakes;
		r.rebase_count = p_rebases;
		r.cancel_count = p_cancels;
		r.ticks_seen = p_ticks;
		r.idle_max_ms = p_peak_idle;
		r.last_idle_ms = p_recent_idle;
		r.last_origin = p_wake_source;
		r.phantom_suspect = phantom_flag();
	endtask

	task automatic report_mismatch(input string what);
		$display("[%0t] mismatch: %s", $realtime, what);
		mismatches++;
	endtask

	task automatic check_field(input string name, input logic [31:0] got,
		input logic [31:0] want);
		if (got !== want)
			report_mismatch($sformatf("result %0d %s: got 0x%0h, expected 0x%0h",
				result_index, name, got, want));
	endtask

	// Track configuration writes, predict on input beats, check output beats.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			reset_controller();
			expected_results.delete();
			result_index = 0;
			leftover_reported = 1'b0;
			outstanding <= 0;
		end else begin
			if (cfg_we) begin
				if (cfg_index == isc_pkg::REG_ARMED)
					p_armed = cfg_data[0];
				else
					p_delay_step = cfg_data;
			end

			if (in_valid && in_ready) begin
				apply_command(command, idle_ms, wake_origin, predicted);
				expected_results.push_back(predicted);
			end

			if (out_valid && out_ready) begin
				observed = {action_taken, ambient_mode, sleep_count, wake_count,
					rebase_count, cancel_count, ticks_seen, idle_max_ms,
					last_idle_ms, last_origin, phantom_suspect};
				if (expected_results.size() == 0) begin
					report_mismatch($sformatf("result %0d arrived with none expected",
						result_index));
				end else begin
					oldest = expected_results.pop_front();
					check_field("action_taken", 32'(observed.action_taken),
						32'(oldest.action_taken));
					check_field("ambient_mode", 32'(observed.ambient_mode),
						32'(oldest.ambient_mode));
					check_field("sleep_count", observed.sleep_count, oldest.sleep_count);
					check_field("wake_count", observed.wake_count, oldest.wake_count);
					check_field("rebase_count", observed.rebase_count,
						oldest.rebase_count);
					check_field("cancel_count", observed.cancel_count,
						oldest.cancel_count);
					check_field("ticks_seen", observed.ticks_seen, oldest.ticks_seen);
					check_field("idle_max_ms", observed.idle_max_ms, oldest.idle_max_ms);
					check_field("last_idle_ms", observed.last_idle_ms,
						oldest.last_idle_ms);
					check_field("last_origin", 32'(observed.last_origin),
						32'(oldest.last_origin));
					check_field("phantom_suspect", 32'(observed.phantom_suspect),
						32'(oldest.phantom_suspect));
				end
				result_index++;
			end

			// Anything still expected once the run has drained is lost.
			if (end_of_test && !leftover_reported) begin
				leftover_reported = 1'b1;
				if (expected_results.size() != 0)
					report_mismatch($sformatf("%0d expected results never arrived",
						expected_results.size()));
			end

			outstanding <= expected_results.size();
		end
	end

endmodule

FILE: tb/tb_idle_standby_controller_core.sv
// ----------------------------------------------------------------------------
// tb_idle_standby_controller_core
// Drives the idle standby controller with a short directed sequence and then
// phases of random standby sessions and noise under several register settings
// and idle patterns on both channels. A checker beside the block predicts and
// compares every result; this module gives the verdict.
// ----------------------------------------------------------------------------
module tb_idle_standby_controller_core;
	timeunit 1ns;
	timeprecision 1ps;

	// Command codes the block ignores.
	localparam logic [2:0] CMD_SPARE_LO = 3'd6;
	localparam logic [2:0] CMD_SPARE_HI = 3'd7;

	localparam int PHASES      = 9;
	localparam int PHASE_BEATS = 70;
	localparam int BURST_TICKS = 130;

	logic        clk;
	logic        arst_n;
	logic        cfg_we;
	logic        cfg_index;
	logic [1:0]  cfg_data;
	logic        in_valid;
	logic        in_ready;
	logic [2:0]  command;
	logic [31:0] idle_ms;
	logic [1:0]  wake_origin;
	logic        out_valid;
	logic        out_ready = 1'b0;
	logic        action_taken;
	logic        ambient_mode;
	logic [31:0] sleep_count;
	logic [31:0] wake_count;
	logic [31:0] rebase_count;
	logic [31:0] cancel_count;
	logic [31:0] ticks_seen;
	logic [31:0] idle_max_ms;
	logic [31:0] last_idle_ms;
	logic [1:0]  last_origin;
	logic        phantom_suspect;

	logic        end_of_test;
	int          outstanding;
	int          mismatches;

	int          src_idle_pct;
	int          sink_idle_pct;
	int          counted_beats;
	logic        cur_armed;
	logic [1:0]  cur_step;

	idle_standby_controller_core u_dut (.*);

	isc_result_checker u_checker (.*);

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	// Receiver: stalls at random in the share given by the current phase.
	always @(posedge clk)
		out_ready <= ($urandom_range(99) >= sink_idle_pct);

	initial begin
		#2_000_000;
		$display("*** FAILED ***");
		$finish;
	end

	function automatic logic [31:0] stim_delay(input logic [1:0] step);
		case (step)
			2'd0:    return 32'd60000;
			2'd1:    return 32'd180000;
			2'd2:    return 32'd300000;
			default: return 32'd600000;
		endcase
	endfunction

	// Register setting of each random phase as {armed, delay_step}.
	function automatic logic [2:0] phase_setting(input int p);
		case (p)
			0:       return {1'b1, 2'd1};
			1:       return {1'b1, 2'd0};
			2:       return {1'b0, 2'd3};
			3:       return {1'b1, 2'd3};
			4:       return {1'b1, 2'd2};
			5:       return {1'b0, 2'd0};
			6:       return {1'b1, 2'd0};
			7:       return {1'b1, 2'd3};
			default: return {1'b0, 2'd1};
		endcase
	endfunction

	// Present one beat, with random idle cycles ahead of it, and hold it
	// until accepted.
	task automatic send_beat(input logic [2:0] cmd, input logic [31:0] idle,
		input logic [1:0] origin);
		while ($urandom_range(99) < src_idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		command <= cmd;
		idle_ms <= idle;
		wake_origin <= origin;
		do @(posedge clk); while (!in_ready);
		if (cmd <= isc_pkg::CMD_CLEAR)
			counted_beats++;
	endtask

	// Write both registers once nothing is in flight; cfg_we stays high
	// across the two writes.
	task automatic set_config(input logic armed_v, input logic [1:0] step_v);
		in_valid <= 1'b0;
		do @(posedge clk); while (outstanding != 0);
		cfg_we <= 1'b1;
		cfg_index <= isc_pkg::REG_ARMED;
		cfg_data <= {1'($urandom_range(1)), armed_v};
		@(posedge clk);
		cfg_index <= isc_pkg::REG_DELAY_STEP;
		cfg_data <= step_v;
		@(posedge clk);
		cfg_we <= 1'b0;
		cur_armed = armed_v;
		cur_step = step_v;
	endtask

	// Any command code, any field values.
	task automatic send_noise();
		send_beat(3'($urandom_range(7)), $urandom, 2'($urandom_range(3)));
	endtask

	// A standby session: some short idles, an entry by the delay or by force,
	// maybe ticks in ambient, then a wake, a cancel or another force.
	task automatic run_session();
		logic [31:0] d;
		d = stim_delay(cur_step);
		repeat ($urandom_range(3))
			send_beat(isc_pkg::CMD_TICK,
				($urandom_range(3) == 0) ? d - 32'd1 : $urandom_range(d - 1),
				2'($urandom_range(3)));
		if ($urandom_range(9) == 0)
			send_beat(isc_pkg::CMD_REBASE, $urandom, 2'($urandom_range(3)));
		case ($urandom_range(3))
			0:       send_beat(isc_pkg::CMD_TICK, d, 2'($urandom_range(3)));
			1:       send_beat(isc_pkg::CMD_TICK, $urandom_range(32'hFFFF_FFFF, d),
				2'($urandom_range(3)));
			2:       send_beat(isc_pkg::CMD_TICK, d + $urandom_range(1000),
				2'($urandom_range(3)));
			default: send_beat(isc_pkg::CMD_FORCE, $urandom, 2'($urandom_range(3)));
		endcase
		repeat ($urandom_range(2))
			send_beat(isc_pkg::CMD_TICK, $urandom, 2'($urandom_range(3)));
		case ($urandom_range(9))
			0, 1, 2, 3, 4, 5: send_beat(isc_pkg::CMD_WAKE, $urandom,
				2'($urandom_range(3)));
			6, 7, 8:          send_beat(isc_pkg::CMD_CANCEL, $urandom,
				2'($urandom_range(3)));
			default:          send_beat(isc_pkg::CMD_FORCE, $urandom,
				2'($urandom_range(3)));
		endcase
		if ($urandom_range(19) == 0)
			send_beat(isc_pkg::CMD_CLEAR, $urandom, 2'($urandom_range(3)));
	endtask

	// Many ticks that never reach the delay, from cleared counters, so the
	// phantom flag comes on.
	task automatic phantom_burst();
		logic [31:0] d;
		d = stim_delay(cur_step);
		send_beat(isc_pkg::CMD_CLEAR, $urandom, 2'($urandom_range(3)));
		repeat (BURST_TICKS)
			send_beat(isc_pkg::CMD_TICK, $urandom_range(d - 1), 2'($urandom_range(3)));
	endtask

	initial begin
		logic [2:0] setting;
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_index = isc_pkg::REG_ARMED;
		cfg_data = 2'd0;
		in_valid = 1'b0;
		command = isc_pkg::CMD_TICK;
		idle_ms = 32'd0;
		wake_origin = 2'd0;
		end_of_test = 1'b0;
		src_idle_pct = 20;
		sink_idle_pct = 46;
		cur_armed = 1'b1;
		cur_step = 2'd1;
		counted_beats = 0;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;

		// Directed part at reset settings: three-minute delay, armed.
		send_beat(isc_pkg::CMD_TICK, 32'd0, 2'd0);
		send_beat(isc_pkg::CMD_TICK, 32'd179999, 2'd3);
		send_beat(isc_pkg::CMD_FORCE, 32'd0, 2'd0);
		send_beat(isc_pkg::CMD_FORCE, 32'd0, 2'd0);
		send_beat(isc_pkg::CMD_TICK, 32'hFFFF_FFFF, 2'd0);
		send_beat(isc_pkg::CMD_WAKE, 32'd0, 2'd0);
		send_beat(isc_pkg::CMD_WAKE, 32'd0, 2'd3);
		send_beat(isc_pkg::CMD_TICK, 32'd180000, 2'd0);
		send_beat(isc_pkg::CMD_CANCEL, 32'd0, 2'd0);
		send_beat(isc_pkg::CMD_CANCEL, 32'd0, 2'd0);
		// Clear while ambient keeps the mode; the cancel then floors at zero.
		send_beat(isc_pkg::CMD_FORCE, 32'd0, 2'd0);
		send_beat(isc_pkg::CMD_CLEAR, 32'd0, 2'd0);
		send_beat(isc_pkg::CMD_CANCEL, 32'd0, 2'd0);
		send_beat(isc_pkg::CMD_REBASE, 32'd0, 2'd0);
		send_beat(CMD_SPARE_LO, 32'hFFFF_FFFF, 2'd3);
		send_beat(CMD_SPARE_HI, 32'hFFFF_FFFF, 2'd3);
		send_beat(isc_pkg::CMD_TICK, 32'd180001, 2'd0);
		send_beat(isc_pkg::CMD_WAKE, 32'd0, 2'd3);
		send_beat(isc_pkg::CMD_FORCE, 32'd0, 2'd0);
		// Disarm while ambient: the mode holds until the wake.
		set_config(1'b0, 2'd3);
		send_beat(isc_pkg::CMD_TICK, 32'hFFFF_FFFF, 2'd0);
		send_beat(isc_pkg::CMD_FORCE, 32'd0, 2'd0);
		send_beat(isc_pkg::CMD_WAKE, 32'd0, 2'd2);
		send_beat(isc_pkg::CMD_FORCE, 32'd0, 2'd0);
		send_beat(isc_pkg::CMD_TICK, 32'd600000, 2'd1);

		// Random phases: receiver idles first, then sender, then neither.
		for (int p = 0; p < PHASES; p++) begin
			if (p < 3) begin
				src_idle_pct = 20;
				sink_idle_pct = 46;
			end else if (p < 6) begin
				src_idle_pct = 46;
				sink_idle_pct = 20;
			end else begin
				src_idle_pct = 0;
				sink_idle_pct = 0;
			end
			setting = phase_setting(p);
			set_config(setting[2], setting[1:0]);
			if (cur_armed && cur_step == 2'd0)
				phantom_burst();
			counted_beats = 0;
			while (counted_beats < PHASE_BEATS) begin
				if ($urandom_range(3) == 0)
					send_noise();
				else
					run_session();
			end
		end

		// Drain, then let the checker look for leftovers.
		in_valid <= 1'b0;
		do @(posedge clk); while (outstanding != 0);
		repeat (8) @(posedge clk);
		end_of_test <= 1'b1;
		repeat (2) @(posedge clk);
		if (mismatches == 0)
			$display("*** PASSED ***");
		else
			$display("*** FAILED ***");
		$finish;
	end

endmodule
